// ===== src/rrlp_pkg.sv =====
// rrlp_pkg: constants, types and helper functions for the response line parser
// no dependencies
`default_nettype none
package rrlp_pkg;
  localparam int LINE_BYTES = 16;
  localparam int TABLE_ENTRIES = 16;
  localparam int AW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 1);

  localparam logic [2:0] EV_ERROR = 3'd0;
  localparam logic [2:0] EV_SS = 3'd1;
  localparam logic [2:0] EV_SE = 3'd2;
  localparam logic [2:0] EV_PING = 3'd3;
  localparam logic [2:0] EV_MODEL = 3'd4;
  localparam logic [2:0] EV_PULSE = 3'd5;
  localparam logic [2:0] EV_MEM = 3'd6;
  localparam logic [2:0] EV_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] index;
    logic [31:0] value;
    logic has;
    logic trunc;
  } rrlp_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic [23:0] addr_of(input logic [3:0] e);
    logic [23:0] a;
    case (e)
      4'd0: a = "055";
      4'd1: a = "140";
      4'd2: a = "088";
      4'd3: a = "08A";
      4'd4: a = "14A";
      4'd5: a = "148";
      4'd6: a = "1E0";
      4'd7: a = "1E1";
      4'd8: a = "1E2";
      4'd9: a = "1E3";
      4'd10: a = "1A0";
      4'd11: a = "1A6";
      4'd12: a = "1A9";
      4'd13: a = "142";
      4'd14: a = "143";
      4'd15: a = "0A9";
      default: a = "055";
    endcase
    return a;
  endfunction

  // returns digit value in [3:0], valid in [4]
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [7:0] u;
    logic [4:0] d;
    u = upper(c);
    d = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b1, 4'(c - 8'h30)};
    else if (hex && u >= 8'h41 && u <= 8'h46) d = {1'b1, 4'(u - 8'h37)};
    return d;
  endfunction
endpackage
`default_nettype wire

// ===== src/rrlp_line_ram.sv =====
// rrlp_line_ram: line character store, one write and one registered read port
// depends on rrlp_pkg
`default_nettype none
module rrlp_line_ram
  import rrlp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  logic [7:0] mem [LINE_BYTES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/rower_response_line_parser.sv =====
// Response line parser. An ordinary byte is taken every cycle while no line is
// being decoded and no event waits, and, leading blanks apart, is stored in the
// 16-byte line memory while the link is open and it has room. A CR or LF starts
// a decode when the link is open. First up to six leading characters are read
// from the memory. For ID lines the address table is then walked one entry per
// cycle through its 16 entries; other lines are classified without the walk.
// The value is parsed one character at a time, each read from the memory and
// then checked. The input is held off from the line end until the event has
// been taken, or until the decode ends for an empty or OK line, which gives none.
// depends on rrlp_pkg and rrlp_line_ram
`default_nettype none
module rower_response_line_parser
  import rrlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_link_open,
  input  wire logic        cfg_we,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [3:0]       out_entry_index,
  output logic signed [31:0] out_value,
  output logic             out_has_value,
  output logic             out_line_truncated
);
  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_TABLE, S_NUM, S_OUT} state_t;

  state_t state_r;
  logic link_r;
  logic [CW-1:0] kept_r, trim_r;
  logic ovf_r;
  logic [7:0] hd_r [6];
  logic [CW-1:0] rd_r;
  logic [3:0] ent_r;
  logic [CW-1:0] pos_r, end_r;
  logic rd_pend_r;
  logic hex_r;
  logic [1:0] ph_r;
  logic neg_r;
  logic [32:0] acc_r;
  rrlp_result_t res_r;

  logic we;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic acc_in, acc_out, is_eol;

  assign acc_in = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;
  assign is_eol = in_rx_byte == 8'h0A || in_rx_byte == 8'h0D;
  assign in_ready = state_r == S_IDLE && !out_valid;
  assign we = acc_in && link_r && !is_eol && !(kept_r == '0 && is_ws(in_rx_byte))
              && kept_r < CW'(LINE_BYTES);
  assign raddr = (state_r == S_NUM) ? pos_r[AW-1:0] : rd_r[AW-1:0];

  rrlp_line_ram u_ram (
    .clk(clk), .we(we), .waddr(kept_r[AW-1:0]), .wdata(in_rx_byte),
    .raddr(raddr), .rdata(rdata)
  );

  logic [32:0] mul;
  logic [4:0] dg;
  always_comb begin
    dg = digit_of(rdata, hex_r);
    mul = hex_r ? {acc_r[28:0], 4'd0} : 33'((34'(acc_r) << 3) + (34'(acc_r) << 1));
  end

  logic [32:0] nacc;
  always_comb begin
    logic [33:0] t;
    t = 34'(mul) + 34'(dg[3:0]);
    if (acc_r > 33'h0_1999_9999 || t > 34'h1_0000_0000) nacc = 33'h1_0000_0000;
    else nacc = t[32:0];
  end

  logic [31:0] fin;
  always_comb begin
    if (neg_r) fin = (acc_r >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(0 - acc_r[31:0]);
    else fin = (acc_r > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : acc_r[31:0];
  end

  logic hi;
  assign hi = hd_r[0] == "I" && hd_r[1] == "D";
  logic [23:0] ta;
  assign ta = addr_of(ent_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      link_r <= 1'b0;
      kept_r <= '0;
      trim_r <= '0;
      ovf_r <= 1'b0;
      res_r <= '0;
      rd_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (cfg_we) link_r <= cfg_link_open;
      case (state_r)
        S_IDLE: begin
          if (acc_in && link_r) begin
            if (is_eol) begin
              state_r <= S_HEAD;
              rd_r <= '0;
              rd_pend_r <= 1'b0;
            end else if (!(kept_r == '0 && is_ws(in_rx_byte))) begin
              if (kept_r < CW'(LINE_BYTES)) begin
                kept_r <= kept_r + 1'b1;
                if (!is_ws(in_rx_byte)) trim_r <= kept_r + 1'b1;
              end else if (!is_ws(in_rx_byte)) ovf_r <= 1'b1;
            end
          end
        end
        S_HEAD: begin
          rd_pend_r <= 1'b1;
          if (rd_pend_r) hd_r[3'(rd_r - 1'b1)] <= rdata;
          if (rd_r == CW'(6) || (rd_pend_r && rd_r >= trim_r)) begin
            state_r <= S_TABLE;
            ent_r <= '0;
            res_r.kind <= EV_UNKNOWN;
            res_r.trunc <= ovf_r;
            res_r.index <= '0;
            res_r.has <= 1'b0;
            res_r.value <= '0;
          end
          rd_r <= rd_r + 1'b1;
        end
        S_TABLE: begin
          if (trim_r == '0 || (trim_r == CW'(2) && hd_r[0] == "O" && hd_r[1] == "K")) begin
            state_r <= S_IDLE;
            kept_r <= '0; trim_r <= '0; ovf_r <= 1'b0;
          end else if (trim_r == CW'(5) && hd_r[0] == "E" && hd_r[1] == "R" &&
                       hd_r[2] == "R" && hd_r[3] == "O" && hd_r[4] == "R") begin
            res_r.kind <= EV_ERROR; state_r <= S_OUT;
          end else if (trim_r == CW'(2) && hd_r[0] == "S" && hd_r[1] == "S") begin
            res_r.kind <= EV_SS; state_r <= S_OUT;
          end else if (trim_r == CW'(2) && hd_r[0] == "S" && hd_r[1] == "E") begin
            res_r.kind <= EV_SE; state_r <= S_OUT;
          end else if (trim_r >= CW'(4) && hd_r[0] == "P" && hd_r[1] == "I" &&
                       hd_r[2] == "N" && hd_r[3] == "G") begin
            res_r.kind <= EV_PING; state_r <= S_OUT;
          end else if (trim_r >= CW'(2) && hd_r[0] == "I" && hd_r[1] == "V") begin
            res_r.kind <= EV_MODEL; state_r <= S_OUT;
          end else if (trim_r >= CW'(2) && hd_r[0] == "P") begin
            res_r.kind <= EV_PULSE; res_r.has <= 1'b1;
            hex_r <= 1'b0; pos_r <= CW'(1); end_r <= trim_r;
            ph_r <= 2'd0; neg_r <= 1'b0; acc_r <= '0; rd_pend_r <= 1'b0;
            state_r <= S_NUM;
          end else if (trim_r > CW'(5) && hi) begin
            if (upper(hd_r[3]) == ta[23:16] && upper(hd_r[4]) == ta[15:8] &&
                upper(hd_r[5]) == ta[7:0] && 5'(ent_r) < 5'(TABLE_ENTRIES)) begin
              res_r.kind <= EV_MEM; res_r.has <= 1'b1; res_r.index <= ent_r;
              hex_r <= !(ent_r >= 4'd6 && ent_r <= 4'd9);
              pos_r <= CW'(6);
              end_r <= (hd_r[2] == "S") ? ((trim_r < CW'(8)) ? trim_r : CW'(8)) :
                       (hd_r[2] == "D") ? ((trim_r < CW'(10)) ? trim_r : CW'(10)) :
                       (hd_r[2] == "T") ? ((trim_r < CW'(12)) ? trim_r : CW'(12)) : CW'(6);
              ph_r <= 2'd0; neg_r <= 1'b0; acc_r <= '0; rd_pend_r <= 1'b0;
              state_r <= S_NUM;
            end else if (ent_r == 4'(TABLE_ENTRIES - 1)) begin
              res_r.kind <= EV_UNKNOWN; state_r <= S_OUT;
            end else ent_r <= ent_r + 1'b1;
          end else begin
            res_r.kind <= EV_UNKNOWN; state_r <= S_OUT;
          end
        end
        S_NUM: begin
          // ph 0 ws/sign, 1 sign done/prefix check, 3 x after 0, 2 digits
          if (!rd_pend_r) begin
            if (pos_r >= end_r) begin
              res_r.value <= fin; state_r <= S_OUT;
            end else rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            case (ph_r)
              2'd0: begin
                if (is_ws(rdata)) pos_r <= pos_r + 1'b1;
                else if (rdata == "+" || rdata == "-") begin
                  neg_r <= rdata == "-"; pos_r <= pos_r + 1'b1; ph_r <= 2'd1;
                end else ph_r <= 2'd1;
              end
              2'd1: begin
                if (hex_r && rdata == "0" && pos_r + CW'(2) < end_r) begin
                  ph_r <= 2'd3; pos_r <= pos_r + 1'b1;
                end else ph_r <= 2'd2;
              end
              2'd3: begin
                if (upper(rdata) == "X") begin
                  pos_r <= pos_r + 1'b1; ph_r <= 2'd2;
                end else begin
                  acc_r <= '0; ph_r <= 2'd2; // the leading 0 contributes nothing
                end
              end
              default: begin
                if (dg[4]) begin
                  acc_r <= nacc; pos_r <= pos_r + 1'b1;
                end else begin
                  res_r.value <= fin; state_r <= S_OUT;
                end
              end
            endcase
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
          kept_r <= '0; trim_r <= '0; ovf_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output holding register
  logic ov_r;
  rrlp_result_t o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else begin
      if (state_r == S_OUT) begin
        ov_r <= 1'b1; o_r <= res_r;
      end else if (acc_out) ov_r <= 1'b0;
    end
  end
  assign out_valid = ov_r;
  assign out_event_kind = o_r.kind;
  assign out_entry_index = o_r.index;
  assign out_value = o_r.value;
  assign out_has_value = o_r.has;
  assign out_line_truncated = o_r.trunc;

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_kept: assert property (@(posedge clk) disable iff (!rst_n)
    trim_r <= kept_r) else $error("trim beyond kept");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result lost");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= CW'(LINE_BYTES)) else $error("store overrun");
endmodule
`default_nettype wire
